// ===== hdl/pbb_pkg.sv =====
// Package for the particle box bounce step block.
// Holds the register map, reset values, the Q16.16 word type and saturation.
// No dependencies.
`default_nettype none

package pbb_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned REG_W     = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY = 1'b1;

  localparam logic [REG_W-1:0] GRAVITY_RST  = 31'd642908;
  localparam logic [REG_W-1:0] BOUNDARY_RST = 31'd655360;

  typedef logic signed [31:0] q16_t;

  typedef struct packed {
    q16_t pos;
    q16_t vel;
  } axis_t;

  function automatic q16_t sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return {v[32], {31{~v[32]}}};
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pbb_wall.sv =====
// Wall test and clamp for one axis of the particle box bounce step.
// Depends on pbb_pkg.
`default_nettype none

module pbb_wall
  import pbb_pkg::*;
(
  input  q16_t  pos,
  input  q16_t  vel,
  input  q16_t  vel_bnc,
  input  q16_t  limit,
  output axis_t res
);

  logic signed [32:0] pos_x;
  logic signed [32:0] mag;
  logic signed [32:0] lim_x;
  logic               hit;

  always_comb begin
    pos_x = {pos[31], pos};
    mag   = pos[31] ? -pos_x : pos_x;
    lim_x = {limit[31], limit};
    hit   = mag > lim_x;
    if (hit) begin
      res.pos = (pos > 0) ? limit : -limit;
      res.vel = vel_bnc;
    end else begin
      res.pos = pos;
      res.vel = vel;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/particle_box_bounce_step.sv =====
// Top level of the particle box bounce step: a five-stage pipeline that moves
// one particle by one time step and bounces it off the box walls.
// Depends on pbb_pkg and pbb_wall.
//
// Usage:
//   Particles enter on the in_ stream, one per transfer, and leave on the
//   out_ stream in the same order, one result per particle. in_tlast is
//   copied to out_tlast.
//   Each particle is registered in stages s1 to s5 in turn, and out_tvalid
//   rises with it in s5. One particle is taken every cycle unless stalled; the
//   depth is set by the two chained multiplies on the y axis (dt times
//   gravity, then velocity times dt), each followed by its own register stage.
//   Each stage holds its item while the next one is full and stalled, so a
//   stall on out_tready fills the empty stages first and then drops
//   in_tready; nothing is lost or repeated.
//   gravity and boundary are written through cfg_wr_en, cfg_index and
//   cfg_wdata and should only change while the pipeline is empty.
//   Reset empties the pipeline and loads the default gravity and boundary.
`default_nettype none

module particle_box_bounce_step
  import pbb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // Fields from bit 0: in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y,
  // in_vel_z, half_width, bounce_factor, dt, one zero pad bit.
  input  logic [255:0]         in_tdata,
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // Fields from bit 0: out_pos_x, out_pos_y, out_pos_z, out_vel_x,
  // out_vel_y, out_vel_z.
  output logic [191:0]         out_tdata,
  output logic                 out_tlast
);

  typedef struct packed {
    q16_t [2:0]  pos;
    q16_t [2:0]  vel;
    logic [30:0] gq;
    q16_t        dx;
    q16_t        dz;
    logic [15:0] rest;
    logic [15:0] dt;
    q16_t        limit;
    logic        last;
  } st1_t;

  typedef struct packed {
    q16_t [2:0]  pos;
    q16_t [2:0]  vel;
    logic [15:0] rest;
    logic [15:0] dt;
    q16_t        limit;
    logic        last;
  } st2_t;

  typedef struct packed {
    q16_t [2:0]               pos;
    q16_t [2:0]               vel;
    q16_t                     dy;
    logic [2:0][47:0]         vr;
    q16_t                     limit;
    logic                     last;
  } st3_t;

  typedef struct packed {
    q16_t [2:0]  pos;
    q16_t [2:0]  vel;
    q16_t [2:0]  vb;
    q16_t        limit;
    logic        last;
  } st4_t;

  typedef struct packed {
    axis_t [2:0] ax;
    logic        last;
  } st5_t;

  logic [REG_W-1:0] gravity_r;
  logic [REG_W-1:0] boundary_r;

  st1_t s1_r, s1_nxt;
  st2_t s2_r, s2_nxt;
  st3_t s3_r, s3_nxt;
  st4_t s4_r, s4_nxt;
  st5_t s5_r, s5_nxt;
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic s1_en, s2_en, s3_en, s4_en, s5_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r  <= GRAVITY_RST;
      boundary_r <= BOUNDARY_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GRAVITY:  gravity_r  <= cfg_wdata;
        CFG_BOUNDARY: boundary_r <= cfg_wdata;
      endcase
    end
  end

  assign s5_en     = !s5_vld_r || out_tready;
  assign s4_en     = !s4_vld_r || s5_en;
  assign s3_en     = !s3_vld_r || s4_en;
  assign s2_en     = !s2_vld_r || s3_en;
  assign s1_en     = !s1_vld_r || s2_en;
  assign in_tready = s1_en;

  q16_t               in_vx;
  q16_t               in_vz;
  logic [30:0]        in_hw;
  logic [15:0]        in_dt;
  logic signed [16:0] in_dt_s;
  logic signed [47:0] in_pdx;
  logic signed [47:0] in_pdz;
  logic [46:0]        in_gprod;

  always_comb begin
    in_vx    = in_tdata[127:96];
    in_vz    = in_tdata[191:160];
    in_hw    = in_tdata[222:192];
    in_dt    = in_tdata[254:239];
    in_dt_s  = $signed({1'b0, in_dt});
    in_pdx   = in_vx * in_dt_s;
    in_pdz   = in_vz * in_dt_s;
    in_gprod = 47'(in_dt) * 47'(gravity_r);
    s1_nxt.pos[0] = in_tdata[31:0];
    s1_nxt.pos[1] = in_tdata[63:32];
    s1_nxt.pos[2] = in_tdata[95:64];
    s1_nxt.vel[0] = in_vx;
    s1_nxt.vel[1] = in_tdata[159:128];
    s1_nxt.vel[2] = in_vz;
    s1_nxt.gq     = in_gprod[46:16];
    s1_nxt.dx     = in_pdx[47:16];
    s1_nxt.dz     = in_pdz[47:16];
    s1_nxt.rest   = in_tdata[238:223];
    s1_nxt.dt     = in_dt;
    s1_nxt.limit  = $signed({1'b0, boundary_r}) - $signed({1'b0, in_hw});
    s1_nxt.last   = in_tlast;
  end

  always_comb begin
    s2_nxt        = '0;
    s2_nxt.pos[0] = sat33($signed({s1_r.pos[0][31], s1_r.pos[0]})
                          + $signed({s1_r.dx[31], s1_r.dx}));
    s2_nxt.pos[1] = s1_r.pos[1];
    s2_nxt.pos[2] = sat33($signed({s1_r.pos[2][31], s1_r.pos[2]})
                          + $signed({s1_r.dz[31], s1_r.dz}));
    s2_nxt.vel[0] = s1_r.vel[0];
    s2_nxt.vel[1] = sat33($signed({s1_r.vel[1][31], s1_r.vel[1]})
                          - $signed({2'b00, s1_r.gq}));
    s2_nxt.vel[2] = s1_r.vel[2];
    s2_nxt.rest   = s1_r.rest;
    s2_nxt.dt     = s1_r.dt;
    s2_nxt.limit  = s1_r.limit;
    s2_nxt.last   = s1_r.last;
  end

  logic signed [16:0] s2_dt_s;
  logic signed [16:0] s2_rest_s;
  logic signed [47:0] s2_pdy;
  logic signed [47:0] s2_vr [3];

  always_comb begin
    s2_dt_s   = $signed({1'b0, s2_r.dt});
    s2_rest_s = $signed({1'b0, s2_r.rest});
    s2_pdy    = $signed(s2_r.vel[1]) * s2_dt_s;
    s3_nxt.pos   = s2_r.pos;
    s3_nxt.vel   = s2_r.vel;
    s3_nxt.dy    = s2_pdy[47:16];
    for (int i = 0; i < 3; i++) begin
      s2_vr[i]     = $signed(s2_r.vel[i]) * s2_rest_s;
      s3_nxt.vr[i] = s2_vr[i];
    end
    s3_nxt.limit = s2_r.limit;
    s3_nxt.last  = s2_r.last;
  end

  logic signed [48:0] s3_nr [3];

  always_comb begin
    s4_nxt.pos    = s3_r.pos;
    s4_nxt.pos[1] = sat33($signed({s3_r.pos[1][31], s3_r.pos[1]})
                          + $signed({s3_r.dy[31], s3_r.dy}));
    s4_nxt.vel    = s3_r.vel;
    for (int i = 0; i < 3; i++) begin
      s3_nr[i]     = -$signed({s3_r.vr[i][47], s3_r.vr[i]});
      s4_nxt.vb[i] = sat33(s3_nr[i][48:16]);
    end
    s4_nxt.limit = s3_r.limit;
    s4_nxt.last  = s3_r.last;
  end

  axis_t wall_res [3];

  for (genvar g = 0; g < 3; g++) begin : g_wall
    pbb_wall u_wall (
      .pos     (s4_r.pos[g]),
      .vel     (s4_r.vel[g]),
      .vel_bnc (s4_r.vb[g]),
      .limit   (s4_r.limit),
      .res     (wall_res[g])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_nxt.ax[i] = wall_res[i];
    end
    s5_nxt.last = s4_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_vld_r <= in_tvalid;
      end
      if (s2_en) begin
        s2_vld_r <= s1_vld_r;
      end
      if (s3_en) begin
        s3_vld_r <= s2_vld_r;
      end
      if (s4_en) begin
        s4_vld_r <= s3_vld_r;
      end
      if (s5_en) begin
        s5_vld_r <= s4_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_r <= s1_nxt;
    end
    if (s2_en) begin
      s2_r <= s2_nxt;
    end
    if (s3_en) begin
      s3_r <= s3_nxt;
    end
    if (s4_en) begin
      s4_r <= s4_nxt;
    end
    if (s5_en) begin
      s5_r <= s5_nxt;
    end
  end

  assign out_tvalid = s5_vld_r;
  assign out_tlast  = s5_r.last;
  assign out_tdata  = {s5_r.ax[2].vel, s5_r.ax[1].vel, s5_r.ax[0].vel,
                       s5_r.ax[2].pos, s5_r.ax[1].pos, s5_r.ax[0].pos};

`ifndef SYNTHESIS
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("in_tready low while the output stage is empty");

  a_stage4_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_vld_r && !s5_en) |=> (s4_vld_r && $stable(s4_r)))
    else $error("stage four lost or changed a stalled item");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  a_stall_keeps_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s5_vld_r && !out_tready) |=> $stable(s5_r))
    else $error("output stage changed during a stall");
`endif

endmodule

`default_nettype wire
